FILE: rtl/pktrx_pkg.sv
// Shared types, codes and the CRC-16/ARC byte step for the packet receiver.
`timescale 1ns / 1ps

package pktrx_pkg;

  // result event codes
  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvPayload = 3'd1;
  localparam logic [2:0] EvStored  = 3'd2;
  localparam logic [2:0] EvCrcErr  = 3'd3;
  localparam logic [2:0] EvWrongNo = 3'd4;
  localparam logic [2:0] EvEnd     = 3'd5;

  localparam logic [7:0]  HeaderByte0 = 8'h75;
  localparam logic [7:0]  HeaderByte1 = 8'h65;
  localparam logic [7:0]  EndByte     = 8'h10;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [8:0]  ExpectedMax = 9'd256;
  localparam logic [7:0]  FirstExpectedReset = 8'd1;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] seq_number;
    logic [7:0] total_packets;
    logic [8:0] expected_number;
  } result_t;

  // reflected CRC-16, one byte, bitwise
  function automatic logic [15:0] crc_arc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/pktrx_parser.sv
// Frame parser: header hunt, field capture, CRC accumulation, sequence check and end-run detection.
`timescale 1ns / 1ps

module pktrx_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,       // beat accepted this cycle
  input  logic [7:0]           rx_byte_i,
  input  logic                 start_i,
  input  logic [7:0]           first_exp_i,
  output pktrx_pkg::result_t   result_o      // result of the current beat
);

  localparam logic [3:0] StHunt    = 4'd0;
  localparam logic [3:0] StH101    = 4'd1;
  localparam logic [3:0] StNum     = 4'd2;
  localparam logic [3:0] StTotal   = 4'd3;
  localparam logic [3:0] StSize    = 4'd4;
  localparam logic [3:0] StPayload = 4'd5;
  localparam logic [3:0] StCrc1    = 4'd6;
  localparam logic [3:0] StCrc2    = 4'd7;
  localparam logic [3:0] StEnd1    = 4'd8;
  localparam logic [3:0] StEnd2    = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [15:0] crc_q, crc_d;
  logic [8:0]  exp_q, exp_d;
  logic [7:0]  num_q, num_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [2:0]  ev;
  logic [7:0]  pay;
  logic [15:0] crc_step;

  assign crc_step = pktrx_pkg::crc_arc_update(crc_q, rx_byte_i);

  always_comb begin
    state_d  = state_q;
    crc_d    = crc_q;
    exp_d    = exp_q;
    num_d    = num_q;
    total_d  = total_q;
    rem_d    = rem_q;
    crc_hi_d = crc_hi_q;
    ev       = pktrx_pkg::EvNone;
    pay      = 8'h00;
    if (start_i) begin
      exp_d    = {1'b0, first_exp_i};
      state_d  = StHunt;
      crc_d    = 16'h0000;
      rem_d    = 8'h00;
      crc_hi_d = 8'h00;
    end else begin
      unique case (state_q)
        StH101: begin
          if (rx_byte_i == pktrx_pkg::HeaderByte1) begin
            crc_d   = crc_step;
            state_d = StNum;
          end
        end
        StNum: begin
          num_d   = rx_byte_i;
          crc_d   = crc_step;
          state_d = StTotal;
        end
        StTotal: begin
          total_d = rx_byte_i;
          crc_d   = crc_step;
          state_d = StSize;
        end
        StSize: begin
          rem_d   = rx_byte_i;
          crc_d   = crc_step;
          state_d = (rx_byte_i == 8'h00) ? StCrc1 : StPayload;
        end
        StPayload: begin
          crc_d = crc_step;
          ev    = pktrx_pkg::EvPayload;
          pay   = rx_byte_i;
          rem_d = rem_q - 8'd1;
          if (rem_d == 8'h00) begin
            state_d = StCrc1;
          end
        end
        StCrc1: begin
          crc_hi_d = rx_byte_i;
          state_d  = StCrc2;
        end
        StCrc2: begin
          if (crc_q[15:8] == crc_hi_q && crc_q[7:0] == rx_byte_i) begin
            if ({1'b0, num_q} == exp_q) begin
              ev = pktrx_pkg::EvStored;
              if (exp_q < pktrx_pkg::ExpectedMax) begin
                exp_d = exp_q + 9'd1;
              end
            end else begin
              ev = pktrx_pkg::EvWrongNo;
            end
          end else begin
            ev = pktrx_pkg::EvCrcErr;
          end
          state_d = StHunt;
        end
        StEnd1: begin
          state_d = (rx_byte_i == pktrx_pkg::EndByte) ? StEnd2 : StHunt;
        end
        StEnd2: begin
          if (rx_byte_i == pktrx_pkg::EndByte) begin
            ev = pktrx_pkg::EvEnd;
          end
          state_d = StHunt;
        end
        default: begin
          // hunt; unused codes land here too
          if (rx_byte_i == pktrx_pkg::HeaderByte0) begin
            crc_d   = pktrx_pkg::crc_arc_update(16'h0000, rx_byte_i);
            state_d = StH101;
          end else if (rx_byte_i == pktrx_pkg::EndByte) begin
            state_d = StEnd1;
          end else begin
            state_d = StHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StHunt;
      crc_q    <= 16'h0000;
      exp_q    <= {1'b0, pktrx_pkg::FirstExpectedReset};
      num_q    <= 8'h00;
      total_q  <= 8'h00;
      rem_q    <= 8'h00;
      crc_hi_q <= 8'h00;
    end else if (step_i) begin
      state_q  <= state_d;
      crc_q    <= crc_d;
      exp_q    <= exp_d;
      num_q    <= num_d;
      total_q  <= total_d;
      rem_q    <= rem_d;
      crc_hi_q <= crc_hi_d;
    end
  end

  assign result_o = '{event_res:       ev,
                      payload_byte:    pay,
                      seq_number:      num_d,
                      total_packets:   total_d,
                      expected_number: exp_d};

endmodule

FILE: rtl/packet_receiver_crc16_seq_check_top.sv
// Top level: stream handshakes, config register and result register around the parser.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while results are drained; every input beat yields exactly one result beat.
// Input is taken whenever the result register is empty or being drained that cycle.
// Reset: async active low; parser returns to header hunt, expected number to 1,
// first-expected register to 1, result register empty.
`timescale 1ns / 1ps

module packet_receiver_crc16_seq_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_wdata_i,     // first_expected_number
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic        s_axis_tuser_i,  // [0] start_session
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [7:0] payload_byte, [15:8] seq_number,
                                       // [23:16] total_packets, [32:24] expected_number
  output logic [2:0]  m_axis_tuser_o   // [2:0] event_res
);

  logic               in_beat;
  logic               out_valid_q;
  logic [7:0]         first_exp_q;
  pktrx_pkg::result_t step_res;
  pktrx_pkg::result_t out_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_exp_q <= pktrx_pkg::FirstExpectedReset;
    end else if (cfg_valid_i) begin
      first_exp_q <= cfg_wdata_i;
    end
  end

  pktrx_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_beat),
    .rx_byte_i   (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .first_exp_i (first_exp_q),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.event_res;
  assign m_axis_tdata_o  = {7'b0000000, out_q.expected_number, out_q.total_packets,
                            out_q.seq_number, out_q.payload_byte};

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the packet receiver: directed table, then random packet traffic.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [3:0] {
    PsHunt, PsHdr2, PsNumber, PsTotal, PsSize, PsPayload, PsCrcHi, PsCrcLo, PsEnd1, PsEnd2
  } parse_state_e;

  // how the driver forms a byte: literal, CRC half xor a mask, or the counter value
  typedef enum logic [1:0] {SrcLit, SrcCrcHi, SrcCrcLo, SrcExpNum} byte_src_e;

  typedef struct packed {
    logic               pinned;
    pktrx_pkg::result_t res;
  } pin_t;

  typedef struct packed {
    byte_src_e          src;
    logic               start;
    logic [7:0]         data;
    logic               pinned;
    pktrx_pkg::result_t res;
  } stim_row_t;

  localparam int DirRows = 25;
  localparam pktrx_pkg::result_t NoRes = '0;

  localparam stim_row_t DirTab [DirRows] = '{
    '{SrcLit,   1'b0, 8'h00, 1'b1, '{pktrx_pkg::EvNone,    8'h00, 8'h00, 8'h00, 9'd1}},
    '{SrcLit,   1'b0, 8'hFF, 1'b1, '{pktrx_pkg::EvNone,    8'h00, 8'h00, 8'h00, 9'd1}},
    '{SrcLit,   1'b0, 8'h10, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h10, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h10, 1'b1, '{pktrx_pkg::EvEnd,     8'h00, 8'h00, 8'h00, 9'd1}},
    // end run broken after one 0x10
    '{SrcLit,   1'b0, 8'h10, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h33, 1'b1, '{pktrx_pkg::EvNone,    8'h00, 8'h00, 8'h00, 9'd1}},
    // zero-size packet, junk byte while waiting for the second header byte
    '{SrcLit,   1'b0, 8'h75, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h00, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h65, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h01, 1'b1, '{pktrx_pkg::EvNone,    8'h00, 8'h01, 8'h00, 9'd1}},
    '{SrcLit,   1'b0, 8'hFF, 1'b1, '{pktrx_pkg::EvNone,    8'h00, 8'h01, 8'hFF, 9'd1}},
    '{SrcLit,   1'b0, 8'h00, 1'b0, NoRes},
    '{SrcCrcHi, 1'b0, 8'h00, 1'b0, NoRes},
    '{SrcCrcLo, 1'b0, 8'h00, 1'b1, '{pktrx_pkg::EvStored,  8'h00, 8'h01, 8'hFF, 9'd2}},
    // two-byte payload with a bad low CRC byte
    '{SrcLit,   1'b0, 8'h75, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h65, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h02, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h05, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h02, 1'b0, NoRes},
    '{SrcLit,   1'b0, 8'h00, 1'b1, '{pktrx_pkg::EvPayload, 8'h00, 8'h02, 8'h05, 9'd2}},
    '{SrcLit,   1'b0, 8'hFF, 1'b1, '{pktrx_pkg::EvPayload, 8'hFF, 8'h02, 8'h05, 9'd2}},
    '{SrcCrcHi, 1'b0, 8'h00, 1'b0, NoRes},
    '{SrcCrcLo, 1'b0, 8'h01, 1'b1, '{pktrx_pkg::EvCrcErr,  8'h00, 8'h02, 8'h05, 9'd2}},
    // session start: byte dropped, counter reloaded, number/total kept
    '{SrcLit,   1'b1, 8'h75, 1'b1, '{pktrx_pkg::EvNone,    8'h00, 8'h02, 8'h05, 9'd1}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b1;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  // predictor state
  parse_state_e pstate        = PsHunt;
  logic [15:0]  crc_acc       = 16'h0000;
  logic [8:0]   exp_cnt       = {1'b0, pktrx_pkg::FirstExpectedReset};
  logic [7:0]   first_exp_reg = pktrx_pkg::FirstExpectedReset;
  logic [7:0]   rx_number     = 8'h00;
  logic [7:0]   rx_total      = 8'h00;
  logic [7:0]   remaining     = 8'h00;
  logic [7:0]   crc_hi_rx     = 8'h00;

  pktrx_pkg::result_t pending_q [$];
  pin_t               pin_q [$];
  pktrx_pkg::result_t pred, want;
  pin_t               pin;
  int      errors = 0;
  int      beats_in = 0;
  int      sent = 0;
  int      ev_seen [8];
  bit      calm = 1'b0;

  packet_receiver_crc16_seq_check_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bit-serial, LSB first; same result as the byte-wise reflected form
  function automatic logic [15:0] crc16_arc_step(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ d[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ pktrx_pkg::CrcPoly;
    end
    return acc;
  endfunction

  function automatic pktrx_pkg::result_t deframe_byte(input logic [7:0] rx, input logic start);
    pktrx_pkg::result_t r;
    r = '0;
    r.event_res = pktrx_pkg::EvNone;
    if (start) begin
      exp_cnt   = {1'b0, first_exp_reg};
      pstate    = PsHunt;
      crc_acc   = 16'h0000;
      remaining = 8'h00;
      crc_hi_rx = 8'h00;
    end else begin
      case (pstate)
        PsHdr2: begin
          if (rx == pktrx_pkg::HeaderByte1) begin
            crc_acc = crc16_arc_step(crc_acc, rx);
            pstate  = PsNumber;
          end
        end
        PsNumber: begin
          rx_number = rx;
          crc_acc   = crc16_arc_step(crc_acc, rx);
          pstate    = PsTotal;
        end
        PsTotal: begin
          rx_total = rx;
          crc_acc  = crc16_arc_step(crc_acc, rx);
          pstate   = PsSize;
        end
        PsSize: begin
          remaining = rx;
          crc_acc   = crc16_arc_step(crc_acc, rx);
          pstate    = (rx == 8'h00) ? PsCrcHi : PsPayload;
        end
        PsPayload: begin
          crc_acc        = crc16_arc_step(crc_acc, rx);
          r.event_res    = pktrx_pkg::EvPayload;
          r.payload_byte = rx;
          remaining      = remaining - 8'd1;
          if (remaining == 8'h00) pstate = PsCrcHi;
        end
        PsCrcHi: begin
          crc_hi_rx = rx;
          pstate    = PsCrcLo;
        end
        PsCrcLo: begin
          if ({crc_hi_rx, rx} != crc_acc) begin
            r.event_res = pktrx_pkg::EvCrcErr;
          end else if ({1'b0, rx_number} == exp_cnt) begin
            r.event_res = pktrx_pkg::EvStored;
            if (exp_cnt < pktrx_pkg::ExpectedMax) exp_cnt = exp_cnt + 9'd1;
          end else begin
            r.event_res = pktrx_pkg::EvWrongNo;
          end
          pstate = PsHunt;
        end
        PsEnd1: pstate = (rx == pktrx_pkg::EndByte) ? PsEnd2 : PsHunt;
        PsEnd2: begin
          if (rx == pktrx_pkg::EndByte) r.event_res = pktrx_pkg::EvEnd;
          pstate = PsHunt;
        end
        default: begin
          if (rx == pktrx_pkg::HeaderByte0) begin
            crc_acc = crc16_arc_step(16'h0000, rx);
            pstate  = PsHdr2;
          end else if (rx == pktrx_pkg::EndByte) begin
            pstate = PsEnd1;
          end else begin
            pstate = PsHunt;
          end
        end
      endcase
    end
    r.seq_number      = rx_number;
    r.total_packets   = rx_total;
    r.expected_number = exp_cnt;
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // beat monitor: config capture, prediction on input, compare on output
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) first_exp_reg = cfg_wdata;
      if (s_valid && s_axis_tready_o) begin
        pred = deframe_byte(s_data, s_user);
        if (pin_q.size() > 0) begin
          pin = pin_q.pop_front();
          if (pin.pinned) pred = pin.res;
        end
        pending_q = {pending_q, pred};
        beats_in++;
      end
      if (m_axis_tvalid_o && m_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual event %0h data %0h",
                   $time, m_axis_tuser_o, m_axis_tdata_o);
          errors++;
        end else begin
          want = pending_q.pop_front();
          check_field("event_res", want.event_res, m_axis_tuser_o);
          check_field("payload_byte", want.payload_byte, m_axis_tdata_o[7:0]);
          check_field("seq_number", want.seq_number, m_axis_tdata_o[15:8]);
          check_field("total_packets", want.total_packets, m_axis_tdata_o[23:16]);
          check_field("expected_number", want.expected_number, m_axis_tdata_o[32:24]);
          check_field("tdata padding", 0, m_axis_tdata_o[39:33]);
          ev_seen[m_axis_tuser_o]++;
        end
      end
    end
  end

  // result-side backpressure
  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 9);
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
        m_ready <= 1'b1;
      end
    end
  end

  // CRC and counter values are read at the falling edge, after the monitor
  // has folded in every beat accepted so far
  task automatic send_beat(input byte_src_e src, input logic [7:0] val, input logic start);
    int gap;
    logic [7:0] d;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    case (src)
      SrcCrcHi:  d = crc_acc[15:8] ^ val;
      SrcCrcLo:  d = crc_acc[7:0] ^ val;
      SrcExpNum: d = exp_cnt[7:0];
      default:   d = val;
    endcase
    s_valid <= 1'b1;
    s_data  <= d;
    s_user  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic settle();
    int n;
    n = 0;
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_q.size() != 0 && n < 1000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_first_expected(input logic [7:0] v);
    settle();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_wdata <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_packet();
    int junk, size, mode, i;
    logic [7:0] b;
    send_beat(SrcLit, pktrx_pkg::HeaderByte0, 1'b0);
    junk = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
    repeat (junk) begin
      b = 8'($urandom);
      if (b == pktrx_pkg::HeaderByte1) b = 8'h00;
      send_beat(SrcLit, b, 1'b0);
    end
    send_beat(SrcLit, pktrx_pkg::HeaderByte1, 1'b0);
    if ($urandom_range(0, 2) == 0) send_beat(SrcLit, 8'($urandom), 1'b0);
    else send_beat(SrcExpNum, 8'h00, 1'b0);
    send_beat(SrcLit, 8'($urandom), 1'b0);
    if ($urandom_range(0, 29) == 0) begin
      size = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(9, 255);
    end else begin
      size = $urandom_range(0, 8);
    end
    send_beat(SrcLit, size[7:0], 1'b0);
    sent += 5 + size;
    for (i = 0; i < size; i++) begin
      // rare session start in the middle of a payload
      if ($urandom_range(0, 400) == 0) begin
        send_beat(SrcLit, 8'($urandom), 1'b1);
        return;
      end
      send_beat(SrcLit, 8'($urandom), 1'b0);
    end
    mode = $urandom_range(0, 9);
    send_beat(SrcCrcHi, (mode == 0) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0);
    send_beat(SrcCrcLo, (mode == 1) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0);
    sent += 2;
  endtask

  task automatic send_end_run();
    send_beat(SrcLit, pktrx_pkg::EndByte, 1'b0);
    if ($urandom_range(0, 2) == 0) begin
      send_beat(SrcLit, 8'($urandom), 1'b0);
    end else begin
      send_beat(SrcLit, pktrx_pkg::EndByte, 1'b0);
      send_beat(SrcLit, ($urandom_range(0, 2) == 0) ? 8'($urandom) : pktrx_pkg::EndByte,
                1'b0);
    end
    sent += 3;
  endtask

  task automatic run_phase(input logic [7:0] first_v);
    int target, pick;
    write_first_expected(first_v);
    // the new setting must not show until the session start
    send_packet();
    send_beat(SrcLit, 8'($urandom), 1'b1);
    target = sent + 150;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_packet();
      end else if (pick < 80) begin
        send_end_run();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) send_beat(SrcLit, 8'($urandom), 1'b0);
      end else begin
        send_beat(SrcLit, 8'($urandom), 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    int i;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DirRows; i++) begin
      pin_q = {pin_q, pin_t'{DirTab[i].pinned, DirTab[i].res}};
      send_beat(DirTab[i].src, DirTab[i].data, DirTab[i].start);
    end

    run_phase(8'd0);
    run_phase(8'd255);   // counter reaches saturation here
    run_phase(8'($urandom_range(2, 254)));
    calm = 1'b1;
    run_phase(8'd1);

    settle();
    if (pending_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_q.size());
      errors++;
    end
    $display("Ran %0d input beats over four first-number settings (0, 255, random, 1).",
             beats_in);
    $display("Events seen: payload %0d, stored %0d, crc error %0d, wrong number %0d, end %0d.",
             ev_seen[pktrx_pkg::EvPayload], ev_seen[pktrx_pkg::EvStored],
             ev_seen[pktrx_pkg::EvCrcErr], ev_seen[pktrx_pkg::EvWrongNo],
             ev_seen[pktrx_pkg::EvEnd]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
